/* src/hlr_pkg.sv */
// Shared types and constants for the histogram largest-rectangle block.
package hlr_pkg;

	localparam int MAX_BARS    = 4096;
	localparam int HEIGHT_BITS = 30;
	localparam int CNT_W       = $clog2(MAX_BARS + 1);
	localparam int IDX_W       = $clog2(MAX_BARS);
	localparam int AREA_W      = 42;
	localparam int PROD_W      = HEIGHT_BITS + CNT_W;

	// one bar as it travels from front to back
	typedef struct packed {
		logic                   ovf;     // bar arrived past the bar limit
		logic                   last;
		logic [HEIGHT_BITS-1:0] height;
	} hlr_item_t;

	// one stack entry: left index and height of a bar
	typedef struct packed {
		logic [IDX_W-1:0]       idx;
		logic [HEIGHT_BITS-1:0] height;
	} hlr_entry_t;

	typedef enum logic [1:0] {
		ST_BAR,
		ST_DRAIN,
		ST_DONE
	} hlr_state_t;

endpackage

/* src/hlr_front.sv */
// Input stage: takes bar requests, tags bars past the limit, feeds the queue.
module hlr_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [hlr_pkg::HEIGHT_BITS-1:0] bar_height,
	input  logic                          last_bar,
	input  logic                          q_full,
	output logic                          q_push,
	output hlr_pkg::hlr_item_t            q_item
);
	import hlr_pkg::*;

	logic             vld_s1;
	hlr_item_t        item_s1;
	logic [CNT_W-1:0] count_q;
	logic             accept;
	logic             at_limit;

	assign in_stall = vld_s1 & q_full;
	assign q_push   = vld_s1 & ~q_full;
	assign q_item   = item_s1;
	assign accept   = in_valid & ~in_stall;
	assign at_limit = (count_q == CNT_W'(MAX_BARS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			count_q <= '0;
		end else begin
			if (accept) begin
				vld_s1 <= 1'b1;
				if (last_bar)
					count_q <= '0;
				else if (!at_limit)
					count_q <= count_q + CNT_W'(1);
			end else if (q_push) begin
				vld_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.ovf    <= at_limit;
			item_s1.last   <= last_bar;
			item_s1.height <= bar_height[HEIGHT_BITS-1:0];
		end
	end

endmodule

/* src/hlr_queue.sv */
// Two-entry queue of classified bars between front and back.
module hlr_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  hlr_pkg::hlr_item_t push_item,
	output logic               full,
	input  logic               pop,
	output logic               not_empty,
	output hlr_pkg::hlr_item_t head
);
	import hlr_pkg::*;

	hlr_item_t  slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;

	assign full      = (fill_q == 2'd2);
	assign not_empty = (fill_q != 2'd0);
	assign head      = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (pop)
				rd_ptr_q <= ~rd_ptr_q;
			case ({push, pop})
				2'b10:   fill_q <= fill_q + 2'd1;
				2'b01:   fill_q <= fill_q - 2'd1;
				default: fill_q <= fill_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q] <= push_item;
	end

	// protect against pointer slips
	assert property (@(posedge clk) disable iff (!arst_n) push |-> !full)
		else $error("queue written while full");
	assert property (@(posedge clk) disable iff (!arst_n) pop |-> not_empty)
		else $error("queue read while empty");
	assert property (@(posedge clk) disable iff (!arst_n)
		(fill_q == 2'd0 || fill_q == 2'd2) |-> (wr_ptr_q == rd_ptr_q))
		else $error("queue pointers disagree with fill count");

endmodule

/* src/hlr_back.sv */
// Stack engine: pushes and pops bars, scores rectangles, emits the result.
module hlr_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        q_valid,
	input  hlr_pkg::hlr_item_t          head,
	output logic                        q_pop,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [hlr_pkg::AREA_W-1:0]  largest_area,
	output logic                        too_many_bars
);
	import hlr_pkg::*;

	hlr_state_t        state_q, state_d;
	logic [CNT_W-1:0]  depth_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              ovf_q;
	logic [AREA_W-1:0] best_q;
	hlr_entry_t        top_q;
	hlr_entry_t        below_q;
	hlr_entry_t        stack_mem_q [MAX_BARS];
	logic [AREA_W-1:0] area_s1;
	logic              score_vld_s1;
	logic              out_vld_q;
	logic [AREA_W-1:0] largest_area_q;
	logic              too_many_q;

	logic              taller;
	logic              do_push;
	logic              do_pop;
	logic              do_done;
	logic              mark_ovf;
	logic [IDX_W-1:0]  wr_addr;
	logic [IDX_W-1:0]  rd_addr;
	logic [CNT_W-1:0]  width;
	logic [PROD_W-1:0] product;

	assign taller  = (depth_q != '0) && (top_q.height > head.height);
	assign wr_addr = IDX_W'(depth_q - CNT_W'(1));
	assign rd_addr = IDX_W'(depth_q - CNT_W'(3));

	// width reaches from just past the entry below to the right edge
	assign width = (depth_q == CNT_W'(1)) ? cnt_q
		: cnt_q - {1'b0, below_q.idx} - CNT_W'(1);
	assign product = {{CNT_W{1'b0}}, top_q.height} * {{HEIGHT_BITS{1'b0}}, width};

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_BAR: begin
				if (q_valid && (head.ovf || !taller) && head.last)
					state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (depth_q == '0)
					state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!out_vld_q || !out_stall)
					state_d = ST_BAR;
			end
			default: state_d = ST_BAR;
		endcase
	end

	always_comb begin
		q_pop    = 1'b0;
		do_push  = 1'b0;
		do_pop   = 1'b0;
		do_done  = 1'b0;
		mark_ovf = 1'b0;
		unique case (state_q)
			ST_BAR: begin
				if (q_valid) begin
					if (head.ovf) begin
						q_pop    = 1'b1;
						mark_ovf = 1'b1;
					end else if (taller) begin
						do_pop = 1'b1;
					end else begin
						do_push = 1'b1;
						q_pop   = 1'b1;
					end
				end
			end
			ST_DRAIN: do_pop  = (depth_q != '0);
			ST_DONE:  do_done = !out_vld_q || !out_stall;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_BAR;
			depth_q      <= '0;
			cnt_q        <= '0;
			ovf_q        <= 1'b0;
			best_q       <= '0;
			score_vld_s1 <= 1'b0;
			out_vld_q    <= 1'b0;
		end else begin
			state_q      <= state_d;
			score_vld_s1 <= do_pop;
			if (do_push) begin
				depth_q <= depth_q + CNT_W'(1);
				cnt_q   <= cnt_q + CNT_W'(1);
			end else if (do_pop) begin
				depth_q <= depth_q - CNT_W'(1);
			end
			if (mark_ovf)
				ovf_q <= 1'b1;
			if (do_done) begin
				cnt_q  <= '0;
				ovf_q  <= 1'b0;
				best_q <= '0;
			end else if (score_vld_s1 && area_s1 > best_q) begin
				best_q <= area_s1;
			end
			if (do_done)
				out_vld_q <= 1'b1;
			else if (!out_stall)
				out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (do_pop)
			area_s1 <= product[AREA_W-1:0];
		if (do_push) begin
			top_q.idx    <= cnt_q[IDX_W-1:0];
			top_q.height <= head.height;
		end else if (do_pop) begin
			top_q <= below_q;
		end
		if (do_done) begin
			largest_area_q <= ovf_q ? '0 : best_q;
			too_many_q     <= ovf_q;
		end
	end

	// stack body below the cached top entry
	always_ff @(posedge clk) begin
		if (do_push && depth_q != '0)
			stack_mem_q[wr_addr] <= top_q;
		if (do_pop)
			below_q <= stack_mem_q[rd_addr];
		else if (do_push)
			below_q <= top_q;
	end

	assign out_valid     = out_vld_q;
	assign largest_area  = largest_area_q;
	assign too_many_bars = too_many_q;

	assert property (@(posedge clk) disable iff (!arst_n) depth_q <= cnt_q)
		else $error("stack deeper than bar count");
	assert property (@(posedge clk) disable iff (!arst_n) do_pop |-> depth_q != '0)
		else $error("pop from empty stack");
	assert property (@(posedge clk) disable iff (!arst_n)
		do_push |-> cnt_q < CNT_W'(MAX_BARS))
		else $error("push past bar limit; front tagging out of step");
	assert property (@(posedge clk) disable iff (!arst_n) do_done |-> !score_vld_s1)
		else $error("result taken with a score still in flight");
	assert property (@(posedge clk) disable iff (!arst_n)
		do_pop |=> depth_q == $past(depth_q) - CNT_W'(1))
		else $error("pop did not shrink the stack");

endmodule

/* src/histogram_largest_rectangle.sv */
// Top level of the histogram largest-rectangle engine.
//
//   channel | handshake          | payload
//   --------+--------------------+-------------------------------
//   in      | in_valid/in_stall  | bar_height[29:0], last_bar
//   out     | out_valid/out_stall| largest_area[41:0], too_many_bars
//
// A bar request first pops every stacked bar taller than itself and is then
// pushed; a bar past the limit is only flagged. The last bar also pops every
// remaining stack entry before the histogram closes.
// The rate is set by the back end: one pop per cycle through the stack
// memory read port and the 30x13 area multiplier.
// Reset (arst_n low) empties the stack and clears counters; the stack
// memory needs no clearing pass. The two-entry queue lets the front keep
// taking bars while the back pops, and out_stall only holds the result
// register and, once the next histogram ends, the back end.
module histogram_largest_rectangle (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [hlr_pkg::HEIGHT_BITS-1:0] bar_height,
	input  logic                            last_bar,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [hlr_pkg::AREA_W-1:0]      largest_area,
	output logic                            too_many_bars
);
	import hlr_pkg::*;

	// front to queue
	logic      fq_push;
	logic      fq_full;
	hlr_item_t fq_item;

	// queue to back
	logic      qb_pop;
	logic      qb_valid;
	hlr_item_t qb_head;

	// front: takes bar requests and tags bars past the limit
	hlr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.bar_height (bar_height),
		.last_bar   (last_bar),
		.q_full     (fq_full),
		.q_push     (fq_push),
		.q_item     (fq_item)
	);

	// decoupling queue
	hlr_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (fq_push),
		.push_item (fq_item),
		.full      (fq_full),
		.pop       (qb_pop),
		.not_empty (qb_valid),
		.head      (qb_head)
	);

	// back: monotonic stack, area scoring and result register
	hlr_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_valid       (qb_valid),
		.head          (qb_head),
		.q_pop         (qb_pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.largest_area  (largest_area),
		.too_many_bars (too_many_bars)
	);

endmodule
